[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds whenever ante holds, at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds at the next edge whenever ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bipd_pkg.sv]
`timescale 1ns / 1ps
// Types, opcode constants and decode helpers of the bytecode predecoder.
package bipd_pkg;

    localparam logic [7:0]  OP_CALL        = 8'hD9;
    localparam logic [7:0]  OP_POP         = 8'h45;
    localparam logic [7:0]  OP_PUSH_FIRST  = 8'hC0;
    localparam logic [7:0]  OP_PUSH_LAST   = 8'hC3;
    localparam logic [7:0]  OP_BREAK       = 8'hFF;
    localparam logic [15:0] BREAK_EXTRA_OP = 16'hFFF5;  // operand -11
    localparam logic [7:0]  OP_BRANCH_B6   = 8'hB6;
    localparam logic [7:0]  OP_BRANCH_B7   = 8'hB7;
    localparam logic [7:0]  OP_BRANCH_B8   = 8'hB8;
    localparam logic [7:0]  OP_ENV_BA      = 8'hBA;
    localparam logic [7:0]  OP_ENV_BB      = 8'hBB;
    localparam logic [7:0]  OP_COMPARE     = 8'h15;

    localparam logic [3:0]  SIZE_ONE_WORD    = 4'd4;
    localparam logic [3:0]  SIZE_TWO_WORDS   = 4'd8;
    localparam logic [3:0]  SIZE_THREE_WORDS = 4'd12;

    localparam logic CFG_CODE_START  = 1'b0;
    localparam logic CFG_CODE_LENGTH = 1'b1;

    typedef logic [1:0] pending_t;

    typedef struct packed {
        logic [31:0]        instr_address;
        logic [7:0]         opcode;
        logic [3:0]         type_low;
        logic [3:0]         type_high;
        logic signed [15:0] operand;
        logic               extra_valid;
        logic [31:0]        extra_word;
        logic [3:0]         instr_size;
        logic [31:0]        branch_target;
        logic [7:0]         compare_kind;
        logic               last;
    } result_t;

    // Number of extra words that follow an instruction's first word.
    function automatic pending_t extra_count(input logic [31:0] word);
        logic [7:0] op;
        logic [3:0] t;
        pending_t   n;
        op = word[31:24];
        t  = word[19:16];
        n  = 2'd0;
        if (op == OP_CALL || op == OP_POP)
        begin
            n = 2'd1;
        end
        else if (op >= OP_PUSH_FIRST && op <= OP_PUSH_LAST)
        begin
            if (t == 4'd0 || t == 4'd3)
            begin
                n = 2'd2;
            end
            else if (t == 4'd1 || t == 4'd2 || t == 4'd4 || t == 4'd5 || t == 4'd6)
            begin
                n = 2'd1;
            end
        end
        else if (op == OP_BREAK && word[15:0] == BREAK_EXTRA_OP)
        begin
            n = 2'd1;
        end
        return n;
    endfunction

    function automatic logic is_jump(input logic [7:0] op);
        return op == OP_BRANCH_B6 || op == OP_BRANCH_B7 || op == OP_BRANCH_B8 ||
               op == OP_ENV_BA || op == OP_ENV_BB;
    endfunction

endpackage

[src/bipd_core.sv]
`timescale 1ns / 1ps
// Decode state and field logic: one code word in, at most one result out.
module bipd_core
    import bipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        accept,
    input  logic [31:0] code_word,
    output logic        res_valid,
    output result_t     res
);

    logic [31:0] code_start_reg, code_start_next;
    logic [31:0] code_length_reg, code_length_next;
    logic [31:0] next_addr_reg, next_addr_next;
    logic [31:0] held_word_reg, held_word_next;
    logic [31:0] held_addr_reg, held_addr_next;
    pending_t    pending_reg, pending_next;
    logic        captured_reg, captured_next;
    logic        finished_reg, finished_next;

    logic        pending_zero;
    logic [31:0] end_addr;
    logic [31:0] first_word;
    logic [31:0] base_addr;
    pending_t    n_extra;
    pending_t    pending_dec;
    logic [3:0]  size;
    logic [31:0] after_addr;
    logic [31:0] offset;
    logic        in_range;
    logic        is_last;
    logic        emit_first;
    logic        emit_extra;

    always_comb
    begin
        pending_zero = (pending_reg == 2'd0);
        end_addr     = code_start_reg + code_length_reg;
        first_word   = pending_zero ? code_word : held_word_reg;
        base_addr    = pending_zero ? next_addr_reg : held_addr_reg;
        n_extra      = extra_count(first_word);
        pending_dec  = pending_reg - 2'd1;
        size         = {n_extra, 2'b00} + SIZE_ONE_WORD;
        after_addr   = base_addr + {28'd0, size};
        offset       = {{7{first_word[22]}}, first_word[22:0], 2'b00};
        in_range     = next_addr_reg < end_addr;
        is_last      = !(after_addr < end_addr);
        emit_first   = accept && !finished_reg && pending_zero && in_range &&
                       (n_extra == 2'd0);
        emit_extra   = accept && !finished_reg && !pending_zero && !captured_reg;
        res_valid    = emit_first || emit_extra;

        res.instr_address = base_addr;
        res.opcode        = first_word[31:24];
        res.type_low      = first_word[19:16];
        res.type_high     = first_word[23:20];
        res.operand       = first_word[15:0];
        res.extra_valid   = !pending_zero;
        res.extra_word    = pending_zero ? 32'd0 : code_word;
        res.instr_size    = size;
        res.branch_target = is_jump(first_word[31:24]) ? base_addr + offset : 32'd0;
        res.compare_kind  = (first_word[31:24] == OP_COMPARE) ? first_word[15:8] : 8'd0;
        res.last          = is_last;
    end

    always_comb
    begin
        code_start_next  = code_start_reg;
        code_length_next = code_length_reg;
        next_addr_next   = next_addr_reg;
        held_word_next   = held_word_reg;
        held_addr_next   = held_addr_reg;
        pending_next     = pending_reg;
        captured_next    = captured_reg;
        finished_next    = finished_reg;

        if (cfg_write && cfg_index == CFG_CODE_LENGTH)
        begin
            code_length_next = cfg_data;
        end

        if (cfg_write && cfg_index == CFG_CODE_START)
        begin
            // restart the entry at the new start address
            code_start_next = cfg_data;
            next_addr_next  = cfg_data;
            pending_next    = 2'd0;
            captured_next   = 1'b0;
            finished_next   = 1'b0;
        end
        else if (accept && !finished_reg)
        begin
            if (pending_zero)
            begin
                if (in_range)
                begin
                    if (n_extra == 2'd0)
                    begin
                        next_addr_next = after_addr;
                        finished_next  = is_last;
                    end
                    else
                    begin
                        held_word_next = code_word;
                        held_addr_next = next_addr_reg;
                        pending_next   = n_extra;
                        captured_next  = 1'b0;
                    end
                end
            end
            else if (!captured_reg)
            begin
                next_addr_next = after_addr;
                if (is_last)
                begin
                    finished_next = 1'b1;
                    pending_next  = 2'd0;
                    captured_next = 1'b0;
                end
                else
                begin
                    pending_next  = pending_dec;
                    captured_next = (pending_dec != 2'd0);
                end
            end
            else
            begin
                // second extra word: drop it
                pending_next = pending_dec;
                if (pending_dec == 2'd0)
                begin
                    captured_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_start_reg  <= 32'd0;
            code_length_reg <= 32'd0;
            next_addr_reg   <= 32'd0;
            pending_reg     <= 2'd0;
            captured_reg    <= 1'b0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            code_start_reg  <= code_start_next;
            code_length_reg <= code_length_next;
            next_addr_reg   <= next_addr_next;
            pending_reg     <= pending_next;
            captured_reg    <= captured_next;
            finished_reg    <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_word_reg <= held_word_next;
        held_addr_reg <= held_addr_next;
    end

endmodule

[src/bipd_out_skid.sv]
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
module bipd_out_skid
    import bipd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_accept,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    always_comb
    begin
        pop             = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg) begin
            // input side is held off; advance the skid beat on a pop
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

endmodule

[src/bytecode_instruction_predecoder.sv]
`timescale 1ns / 1ps
// Top level of the bytecode instruction predecoder.
//
// Usage:
//   Input channel (in_valid/in_ready/code_word) carries one 32-bit code word
//   per beat, in address order, starting at code_start.
//   Output channel (out_valid/out_ready + fields) carries one decoded
//   instruction per beat. An instruction with extra words gives its beat
//   after its first extra word; a second push extra word gives none.
//   Configuration: cfg_write with cfg_index 0 sets code_start and restarts
//   decoding there; index 1 sets code_length. Write only while idle.
// Output: a result is registered from the beat of the word that completes
//   it into the output register, or into the skid register while stalled.
// Throughput: one code word per cycle while in_ready is high; decode is a single
//   registered pass through field logic, three 32-bit adders and two compares.
// Stall: a two-entry output buffer lets one more result be taken while the
//   receiver holds out_ready low; in_ready drops once both entries are full.
// Reset: clears code_start, code_length and the address counter to zero and
//   empties the output buffer; with zero length every word is dropped
//   until the registers are written.
module bytecode_instruction_predecoder
    import bipd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        code_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        instr_address,
    output logic [7:0]         opcode,
    output logic [3:0]         type_low,
    output logic [3:0]         type_high,
    output logic signed [15:0] operand,
    output logic               extra_valid,
    output logic [31:0]        extra_word,
    output logic [3:0]         instr_size,
    output logic [31:0]        branch_target,
    output logic [7:0]         compare_kind,
    output logic               last
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    // a code word is taken when in_valid is high and the skid entry is free
    assign accept = in_valid && in_ready;

    bipd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .code_word (code_word),
        .res_valid (res_valid),
        .res       (res)
    );

    bipd_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // unpack the result beat onto the field ports
    assign instr_address = out_data.instr_address;
    assign opcode        = out_data.opcode;
    assign type_low      = out_data.type_low;
    assign type_high     = out_data.type_high;
    assign operand       = out_data.operand;
    assign extra_valid   = out_data.extra_valid;
    assign extra_word    = out_data.extra_word;
    assign instr_size    = out_data.instr_size;
    assign branch_target = out_data.branch_target;
    assign compare_kind  = out_data.compare_kind;
    assign last          = out_data.last;

endmodule

[src/bipd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the predecoder, bound to the top level.
`include "assert_macros.svh"

module bipd_checker
    import bipd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] instr_address,
    input logic [7:0]  opcode,
    input logic        extra_valid,
    input logic [31:0] extra_word,
    input logic [3:0]  instr_size,
    input logic [31:0] branch_target,
    input logic [7:0]  compare_kind
);

    `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(instr_address), "result beat changed while stalled")

    `ASSERT_IMPLIES(a_size_legal, out_valid,
        instr_size == SIZE_ONE_WORD || instr_size == SIZE_TWO_WORDS ||
        instr_size == SIZE_THREE_WORDS, "illegal instruction size")

    `ASSERT_IMPLIES(a_extra_size, out_valid,
        extra_valid == (instr_size != SIZE_ONE_WORD) && (extra_valid || extra_word == 32'd0),
        "extra word flag disagrees with size")

    `ASSERT_IMPLIES(a_kind_compare_only, out_valid && compare_kind != 8'd0,
        opcode == OP_COMPARE, "compare kind on non-compare opcode")

    `ASSERT_IMPLIES(a_target_jump_only, out_valid && branch_target != 32'd0,
        is_jump(opcode), "jump target on non-jump opcode")

endmodule

bind bytecode_instruction_predecoder bipd_checker u_bipd_checker (.*);
